[hdl/home_computer_io_port_block_macros.svh]
// ----------------------------------------------------------------------------
// I/O port block assertion macros
// Shared property wrappers for the checker of the I/O port block.
// ----------------------------------------------------------------------------
`ifndef HOME_COMPUTER_IO_PORT_BLOCK_MACROS_SVH
`define HOME_COMPUTER_IO_PORT_BLOCK_MACROS_SVH

// Checked on every clock edge outside reset.
`define HCIO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HCIO_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hdl/hcio_pkg.sv]
// ----------------------------------------------------------------------------
// I/O port block package
// Word types, operation codes and port decode constants.
// ----------------------------------------------------------------------------
package hcio_pkg;

    localparam int KEY_ROW_COUNT = 8;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_PRESS   = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    // Low address bytes of the decoded ports.
    localparam logic [7:0] PORT_ULA_LO   = 8'hFE;
    localparam logic [7:0] PORT_JOY_LO   = 8'h1F;
    localparam logic [7:0] PORT_CTRL_LO  = 8'h7F;
    localparam logic [7:0] PORT_PAGE_LO  = 8'hFD;
    // High address bytes that qualify the control and paging ports.
    localparam logic [7:0] PORT_LED_HI   = 8'hFF;
    localparam logic [7:0] PORT_TURBO_HI = 8'hFE;
    localparam logic [7:0] PORT_PAGE_HI  = 8'h7F;

    localparam logic [7:0] BUS_IDLE      = 8'hFF;
    localparam logic [1:0] LED_RESET     = 2'b11;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] port_high;
        logic [7:0] port_low;
        logic [7:0] write_data;
        logic [7:0] key_code;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] border_color;
        logic       speaker_level;
        logic [2:0] ram_bank;
        logic       rom_bank;
        logic       shadow_screen;
        logic       paging_locked;
        logic       turbo_on;
        logic       rom_hooks_on;
        logic [1:0] led_bits;
        logic       any_key_on_read;
        logic       all_keys_released;
    } t_out_word;

    // Control state apart from the key rows.
    typedef struct packed {
        logic [7:0] joystick;
        logic [2:0] border;
        logic       speaker;
        logic [7:0] paging;
        logic       lock;
        logic       turbo;
        logic       hooks;
        logic [1:0] led;
    } t_state;

endpackage

[hdl/hcio_if.sv]
// ----------------------------------------------------------------------------
// I/O port block channels
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface hcio_in_if;
    logic                valid;
    logic                ready;
    hcio_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcio_out_if;
    logic                valid;
    logic                ready;
    hcio_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/hcio_exec.sv]
// ----------------------------------------------------------------------------
// I/O port block event logic
// Decodes one event word against the current state and forms the next
// state and the result word.
// ----------------------------------------------------------------------------
module hcio_exec #(
    parameter int KEY_ROW_COUNT = hcio_pkg::KEY_ROW_COUNT
) (
    input  hcio_pkg::t_in_word  i_word,
    input  hcio_pkg::t_state    i_state,
    input  logic [7:0]          i_rows [KEY_ROW_COUNT],
    output hcio_pkg::t_state    o_state,
    output logic [7:0]          o_rows [KEY_ROW_COUNT],
    output hcio_pkg::t_out_word o_result
);

    logic [7:0] w_mask;
    logic [7:0] w_read;
    logic [7:0] w_and;
    logic       w_any;

    // A column of eight or more lies outside the byte and touches nothing.
    assign w_mask = i_word.key_code[3] ? 8'h00 : (8'h01 << i_word.key_code[2:0]);

    always_comb begin
        o_state = i_state;
        o_rows  = i_rows;
        w_read  = hcio_pkg::BUS_IDLE;
        w_any   = 1'b0;
        case (hcio_pkg::t_op'(i_word.operation))
            hcio_pkg::OP_WRITE: begin
                if (i_word.port_low == hcio_pkg::PORT_ULA_LO) begin
                    o_state.border  = i_word.write_data[2:0];
                    o_state.speaker = i_word.write_data[4];
                end else if (i_word.port_low == hcio_pkg::PORT_CTRL_LO) begin
                    if (i_word.port_high == hcio_pkg::PORT_LED_HI) begin
                        o_state.led = i_word.write_data[1:0];
                    end else if (i_word.port_high == hcio_pkg::PORT_TURBO_HI) begin
                        o_state.turbo = ~i_word.write_data[0];
                        o_state.hooks = ~i_word.write_data[1];
                    end
                end else if (i_word.port_low == hcio_pkg::PORT_PAGE_LO &&
                             i_word.port_high == hcio_pkg::PORT_PAGE_HI &&
                             !i_state.lock) begin
                    o_state.paging = i_word.write_data;
                    o_state.lock   = i_word.write_data[5];
                end
            end
            hcio_pkg::OP_READ: begin
                if (i_word.port_low == hcio_pkg::PORT_ULA_LO) begin
                    // A low bit of the high address byte selects its row.
                    for (int r = 0; r < KEY_ROW_COUNT; r++) begin
                        if (!i_word.port_high[r]) begin
                            w_read = w_read & i_rows[r];
                        end
                    end
                    w_any = (w_read != hcio_pkg::BUS_IDLE);
                end else if (i_word.port_low == hcio_pkg::PORT_JOY_LO) begin
                    w_read = i_state.joystick;
                end else if (i_word.port_low == hcio_pkg::PORT_CTRL_LO) begin
                    if (i_word.port_high == hcio_pkg::PORT_LED_HI) begin
                        w_read = {6'd0, i_state.led};
                    end else if (i_word.port_high == hcio_pkg::PORT_TURBO_HI) begin
                        w_read = {6'h3F, ~i_state.hooks, ~i_state.turbo};
                    end
                end
            end
            hcio_pkg::OP_PRESS: begin
                if (i_word.key_code[7]) begin
                    o_state.joystick = i_state.joystick | w_mask;
                end else begin
                    for (int r = 0; r < KEY_ROW_COUNT; r++) begin
                        if (i_word.key_code[6:4] == 3'(r)) begin
                            o_rows[r] = i_rows[r] & ~w_mask;
                        end
                    end
                end
            end
            hcio_pkg::OP_RELEASE: begin
                if (i_word.key_code[7]) begin
                    o_state.joystick = i_state.joystick & ~w_mask;
                end else begin
                    for (int r = 0; r < KEY_ROW_COUNT; r++) begin
                        if (i_word.key_code[6:4] == 3'(r)) begin
                            o_rows[r] = i_rows[r] | w_mask;
                        end
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    always_comb begin
        w_and = 8'hFF;
        for (int r = 0; r < KEY_ROW_COUNT; r++) begin
            w_and = w_and & o_rows[r];
        end
    end

    always_comb begin
        o_result.read_data         = w_read;
        o_result.border_color      = o_state.border;
        o_result.speaker_level     = o_state.speaker;
        o_result.ram_bank          = o_state.paging[2:0];
        o_result.rom_bank          = o_state.paging[4];
        o_result.shadow_screen     = o_state.paging[3];
        o_result.paging_locked     = o_state.lock;
        o_result.turbo_on          = o_state.turbo;
        o_result.rom_hooks_on      = o_state.hooks;
        o_result.led_bits          = o_state.led;
        o_result.any_key_on_read   = w_any;
        o_result.all_keys_released = (w_and == 8'hFF);
    end

endmodule

[hdl/home_computer_io_port_block.sv]
// An accepted event word is held in the input register, and its result word is then captured in the result register.
// Throughput: one event word per cycle; the input register and the result
// register form a two-stage pipeline that stalls only on output backpressure.
// Reset (synchronous, active low) clears all rows to released, LEDs to 3,
// every other state register to zero, and empties both pipeline stages.
// ----------------------------------------------------------------------------
// I/O port block top level
// Keyboard matrix, joystick, border, speaker, paging and board control ports.
// ----------------------------------------------------------------------------
module home_computer_io_port_block #(
    parameter int KEY_ROW_COUNT = hcio_pkg::KEY_ROW_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hcio_in_if.sink          i_in,
    hcio_out_if.source       o_out
);

    // Stage one holds the accepted event word. Stage two applies it to the
    // state and captures the result word in the output register, so the
    // state is updated exactly once per event, in arrival order.
    logic                r_in_valid;
    hcio_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    hcio_pkg::t_out_word r_out_word;

    // Architectural state of the ports and the key matrix.
    hcio_pkg::t_state    r_state;
    logic [7:0]          r_rows [KEY_ROW_COUNT];

    hcio_pkg::t_state    n_state;
    logic [7:0]          n_rows [KEY_ROW_COUNT];
    hcio_pkg::t_out_word n_out_word;

    // The result register may load when it is empty or its word is taken.
    // The input register may load when it is empty or moves on this cycle.
    logic w_advance;
    logic w_take;

    assign w_advance   = !r_out_valid || o_out.ready;
    assign w_take      = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    hcio_exec #(
        .KEY_ROW_COUNT (KEY_ROW_COUNT)
    ) u_exec (
        .i_word   (r_in_word),
        .i_state  (r_state),
        .i_rows   (r_rows),
        .o_state  (n_state),
        .o_rows   (n_rows),
        .o_result (n_out_word)
    );

    // Pipeline control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (w_take) begin
            r_in_word <= i_in.data;
        end
        if (w_advance && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    // State moves only when an event passes from stage one to stage two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.joystick <= 8'd0;
            r_state.border   <= 3'd0;
            r_state.speaker  <= 1'b0;
            r_state.paging   <= 8'd0;
            r_state.lock     <= 1'b0;
            r_state.turbo    <= 1'b0;
            r_state.hooks    <= 1'b0;
            r_state.led      <= hcio_pkg::LED_RESET;
            for (int r = 0; r < KEY_ROW_COUNT; r++) begin
                r_rows[r] <= 8'hFF;
            end
        end else if (w_advance && r_in_valid) begin
            r_state <= n_state;
            r_rows  <= n_rows;
        end
    end

endmodule

[hdl/hcio_checker.sv]
// ----------------------------------------------------------------------------
// I/O port block checker
// Port-level properties of the I/O port block, bound to its top level.
// ----------------------------------------------------------------------------
`include "home_computer_io_port_block_macros.svh"

module hcio_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input hcio_pkg::t_out_word i_out_data
);

    `HCIO_ASSERT_ALWAYS(a_empty_after_reset, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `HCIO_ASSERT(a_stall_holds, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "stalled result word changed")
    `HCIO_ASSERT(a_lock_sticky, $past(i_rst_n) && $past(i_out_valid) && $past(i_out_data.paging_locked) && i_out_valid |-> i_out_data.paging_locked, "paging lock released")
    `HCIO_ASSERT(a_key_read_data, i_out_valid && i_out_data.any_key_on_read |-> i_out_data.read_data != hcio_pkg::BUS_IDLE, "key flag with idle read data")
    `HCIO_ASSERT(a_key_vs_release, i_out_valid && i_out_data.any_key_on_read |-> !i_out_data.all_keys_released, "key seen while all keys released")

endmodule

bind home_computer_io_port_block hcio_checker u_hcio_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I/O port block testbench
// Drives port writes, port reads and key events into the block and checks
// every result word against a cycle-free model of the port state.
// ----------------------------------------------------------------------------
module tb_top;

    // Bit positions inside written data bytes.
    localparam int SPEAKER_BIT = 4;
    localparam int SHADOW_BIT  = 3;
    localparam int ROM_BIT     = 4;
    localparam int LOCK_BIT    = 5;
    localparam int TURBO_BIT   = 0;
    localparam int HOOKS_BIT   = 1;
    // Bit 3 of a key code set means a column past the end of the row.
    localparam int COL_OVER_BIT = 3;
    localparam int JOY_SEL_BIT  = 7;

    localparam int IDLE_PCT        = 26;
    localparam int RANDOM_WORDS    = 1400;
    localparam int SWEEP_AT_A      = 500;
    localparam int SWEEP_AT_B      = 1100;
    localparam int MID_DRAIN_AT    = 750;
    localparam int LOCK_AT         = 1300;
    localparam int TAIL_CYCLES     = 10;
    localparam int STALL_LIMIT     = 1000;
    localparam int REPORT_LIMIT    = 50;

    typedef struct {
        hcio_pkg::t_in_word word;
        bit                 drain_first;   // hold the word back until nothing is outstanding
    } t_port_event;

    logic i_clk;
    logic i_rst_n;

    hcio_in_if  event_ch ();
    hcio_out_if result_ch ();

    home_computer_io_port_block dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (event_ch),
        .o_out   (result_ch)
    );

    // Words still to be sent, and the port state each accepted word should show.
    t_port_event         event_queue[$];
    hcio_pkg::t_out_word outcome_queue[$];

    // Model of the port state: key rows are active low, everything else is
    // kept in the package's state record.
    logic [7:0]       key_matrix [hcio_pkg::KEY_ROW_COUNT];
    hcio_pkg::t_state board;

    int words_sent;
    int results_seen;
    int total_events;
    int mismatch_count;
    int key_hits;
    int op_count [4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of one event: update the state, return the word the block shows.
    // ------------------------------------------------------------------------
    function automatic hcio_pkg::t_out_word predict_outcome(hcio_pkg::t_in_word w);
        hcio_pkg::t_out_word r;
        logic [7:0]          column_bit;
        logic [2:0]          row;
        logic [7:0]          rows_and;
        column_bit = w.key_code[COL_OVER_BIT] ? 8'h00 : (8'h01 << w.key_code[2:0]);
        row = w.key_code[6:4];
        r = '0;
        r.read_data = hcio_pkg::BUS_IDLE;
        op_count[w.operation]++;
        case (hcio_pkg::t_op'(w.operation))
            hcio_pkg::OP_WRITE: begin
                if (w.port_low == hcio_pkg::PORT_ULA_LO) begin
                    // Mic bit is not modeled; only border and speaker land.
                    board.border  = w.write_data[2:0];
                    board.speaker = w.write_data[SPEAKER_BIT];
                end else if (w.port_low == hcio_pkg::PORT_CTRL_LO) begin
                    // Both qualifying high bytes have bit 7 set, so device-bus
                    // accesses and the other high bytes fall through untouched.
                    if (w.port_high == hcio_pkg::PORT_LED_HI) begin
                        board.led = w.write_data[1:0];
                    end else if (w.port_high == hcio_pkg::PORT_TURBO_HI) begin
                        board.turbo = ~w.write_data[TURBO_BIT];
                        board.hooks = ~w.write_data[HOOKS_BIT];
                    end
                end else if (w.port_high == hcio_pkg::PORT_PAGE_HI
                             && w.port_low == hcio_pkg::PORT_PAGE_LO
                             && !board.lock) begin
                    board.paging = w.write_data;
                    if (w.write_data[LOCK_BIT]) begin
                        board.lock = 1'b1;
                    end
                end
            end
            hcio_pkg::OP_READ: begin
                if (w.port_low == hcio_pkg::PORT_ULA_LO) begin
                    // A low bit of the high address byte selects its row.
                    for (int i = 0; i < hcio_pkg::KEY_ROW_COUNT; i++) begin
                        if (!w.port_high[i]) begin
                            r.read_data &= key_matrix[i];
                        end
                    end
                    r.any_key_on_read = (r.read_data != hcio_pkg::BUS_IDLE);
                end else if (w.port_low == hcio_pkg::PORT_JOY_LO) begin
                    r.read_data = board.joystick;
                end else if (w.port_low == hcio_pkg::PORT_CTRL_LO) begin
                    if (w.port_high == hcio_pkg::PORT_LED_HI) begin
                        r.read_data = {6'b0, board.led};
                    end else if (w.port_high == hcio_pkg::PORT_TURBO_HI) begin
                        r.read_data = {6'h3F, ~board.hooks, ~board.turbo};
                    end
                end
            end
            hcio_pkg::OP_PRESS: begin
                if (w.key_code[JOY_SEL_BIT]) begin
                    board.joystick |= column_bit;
                end else begin
                    key_matrix[row] &= ~column_bit;
                end
            end
            hcio_pkg::OP_RELEASE: begin
                if (w.key_code[JOY_SEL_BIT]) begin
                    board.joystick &= ~column_bit;
                end else begin
                    key_matrix[row] |= column_bit;
                end
            end
        endcase
        rows_and = 8'hFF;
        for (int i = 0; i < hcio_pkg::KEY_ROW_COUNT; i++) begin
            rows_and &= key_matrix[i];
        end
        r.border_color      = board.border;
        r.speaker_level     = board.speaker;
        r.ram_bank          = board.paging[2:0];
        r.rom_bank          = board.paging[ROM_BIT];
        r.shadow_screen     = board.paging[SHADOW_BIT];
        r.paging_locked     = board.lock;
        r.turbo_on          = board.turbo;
        r.rom_hooks_on      = board.hooks;
        r.led_bits          = board.led;
        r.all_keys_released = (rows_and == 8'hFF);
        return r;
    endfunction

    task automatic queue_event(hcio_pkg::t_op op, logic [7:0] hi, logic [7:0] lo,
                               logic [7:0] data, logic [7:0] code, bit drain);
        t_port_event e;
        e.word.operation  = op;
        e.word.port_high  = hi;
        e.word.port_low   = lo;
        e.word.write_data = data;
        e.word.key_code   = code;
        e.drain_first     = drain;
        event_queue.push_back(e);
    endtask

    // Random event aimed mostly at decoded ports, with real key columns
    // most of the time. Before the lock phase, paging writes keep bit 5 clear
    // so that the paging register stays writable for most of the run.
    function automatic hcio_pkg::t_in_word random_event(bit allow_lock);
        hcio_pkg::t_in_word w;
        w.operation  = 2'($urandom_range(0, 3));
        w.port_high  = 8'($urandom);
        w.port_low   = 8'($urandom);
        w.write_data = 8'($urandom);
        w.key_code   = 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1: w.port_low = hcio_pkg::PORT_ULA_LO;
            2: w.port_low = hcio_pkg::PORT_JOY_LO;
            3: begin
                w.port_low  = hcio_pkg::PORT_CTRL_LO;
                w.port_high = hcio_pkg::PORT_LED_HI;
            end
            4: begin
                w.port_low  = hcio_pkg::PORT_CTRL_LO;
                w.port_high = hcio_pkg::PORT_TURBO_HI;
            end
            5: w.port_low = hcio_pkg::PORT_CTRL_LO;
            6, 7: begin
                w.port_low  = hcio_pkg::PORT_PAGE_LO;
                w.port_high = hcio_pkg::PORT_PAGE_HI;
            end
            default: ;
        endcase
        if (!allow_lock && w.port_low == hcio_pkg::PORT_PAGE_LO
            && w.port_high == hcio_pkg::PORT_PAGE_HI) begin
            w.write_data[LOCK_BIT] = 1'b0;
        end
        if ($urandom_range(0, 9) < 8) begin
            w.key_code[COL_OVER_BIT] = 1'b0;
        end
        return w;
    endfunction

    // Release every key of the matrix so the all-released flag comes back.
    task automatic queue_release_sweep();
        for (int r = 0; r < hcio_pkg::KEY_ROW_COUNT; r++) begin
            for (int c = 0; c < 8; c++) begin
                queue_event(hcio_pkg::OP_RELEASE, 8'($urandom), 8'($urandom),
                            8'($urandom), 8'((r << 4) | c), 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------------
    initial begin
        t_port_event e;
        i_rst_n          = 1'b0;
        event_ch.valid   = 1'b0;
        event_ch.data    = '0;
        result_ch.ready  = 1'b0;
        words_sent       = 0;
        results_seen     = 0;
        mismatch_count   = 0;
        key_hits         = 0;
        op_count         = '{default: 0};
        for (int i = 0; i < hcio_pkg::KEY_ROW_COUNT; i++) begin
            key_matrix[i] = 8'hFF;
        end
        board     = '0;
        board.led = hcio_pkg::LED_RESET;

        // Directed part: the keyboard matrix first, with nothing held, one key,
        // a row outside the selection and a column past the row.
        queue_event(hcio_pkg::OP_READ,    8'h00, hcio_pkg::PORT_ULA_LO, 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_PRESS,   8'h00, 8'h00,                 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_READ,    8'hFE, hcio_pkg::PORT_ULA_LO, 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_PRESS,   8'h00, 8'h00,                 8'h00, 8'h77, 1'b0);
        queue_event(hcio_pkg::OP_PRESS,   8'h00, 8'h00,                 8'h00, 8'h7F, 1'b0);
        queue_event(hcio_pkg::OP_READ,    8'h7F, hcio_pkg::PORT_ULA_LO, 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_RELEASE, 8'hFF, 8'hFF,                 8'hFF, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_RELEASE, 8'hFF, 8'hFF,                 8'hFF, 8'h77, 1'b0);
        // Joystick lines, including a column past the byte.
        queue_event(hcio_pkg::OP_PRESS,   8'h00, 8'h00,                 8'h00, 8'h84, 1'b0);
        queue_event(hcio_pkg::OP_PRESS,   8'h00, 8'h00,                 8'h00, 8'hFF, 1'b0);
        queue_event(hcio_pkg::OP_READ,    8'h00, hcio_pkg::PORT_JOY_LO, 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_RELEASE, 8'h00, 8'h00,                 8'h00, 8'h84, 1'b0);
        // Border and speaker; the mic bit alone must change nothing visible.
        queue_event(hcio_pkg::OP_WRITE,   8'h00, hcio_pkg::PORT_ULA_LO, 8'hFF, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_WRITE,   8'hA5, hcio_pkg::PORT_ULA_LO, 8'h08, 8'h00, 1'b0);
        // Control port: device bus, LEDs, turbo and an unqualified high byte.
        queue_event(hcio_pkg::OP_WRITE, 8'h7F, hcio_pkg::PORT_CTRL_LO, 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_READ,  8'h00, hcio_pkg::PORT_CTRL_LO, 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_WRITE, hcio_pkg::PORT_LED_HI, hcio_pkg::PORT_CTRL_LO,
                    8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_READ,  hcio_pkg::PORT_LED_HI, hcio_pkg::PORT_CTRL_LO,
                    8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_WRITE, hcio_pkg::PORT_TURBO_HI, hcio_pkg::PORT_CTRL_LO,
                    8'hFC, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_READ,  hcio_pkg::PORT_TURBO_HI, hcio_pkg::PORT_CTRL_LO,
                    8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_WRITE, 8'h80, hcio_pkg::PORT_CTRL_LO, 8'h00, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_READ,  8'hC3, hcio_pkg::PORT_CTRL_LO, 8'h00, 8'h00, 1'b0);
        // Paging with every visible bit set, then a near miss on the high byte.
        queue_event(hcio_pkg::OP_WRITE, hcio_pkg::PORT_PAGE_HI, hcio_pkg::PORT_PAGE_LO,
                    8'h1F, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_WRITE, 8'h7E, hcio_pkg::PORT_PAGE_LO, 8'h07, 8'h00, 1'b0);
        queue_event(hcio_pkg::OP_READ,  8'h12, 8'h34, 8'h00, 8'h00, 1'b0);

        // Random part. Two release sweeps bring the matrix back to all keys
        // up; the lock write comes late, after a drain, and the paging writes
        // that follow it must be ignored.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == SWEEP_AT_A || i == SWEEP_AT_B) begin
                queue_release_sweep();
            end
            if (i == LOCK_AT) begin
                queue_event(hcio_pkg::OP_WRITE, hcio_pkg::PORT_PAGE_HI,
                            hcio_pkg::PORT_PAGE_LO, 8'($urandom) | (8'h01 << LOCK_BIT),
                            8'($urandom), 1'b1);
            end
            e.word        = random_event(i > LOCK_AT);
            e.drain_first = (i == MID_DRAIN_AT);
            event_queue.push_back(e);
        end
        total_events = event_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Counters change at clock edges, so look at them mid-cycle.
        while (results_seen != total_events) begin
            @(negedge i_clk);
        end
        // Any result word arriving from here on is a stray word.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d words checked (%0d writes, %0d reads, %0d presses, %0d releases).",
                 results_seen, op_count[hcio_pkg::OP_WRITE], op_count[hcio_pkg::OP_READ],
                 op_count[hcio_pkg::OP_PRESS], op_count[hcio_pkg::OP_RELEASE]);
        $display("Summary: %0d keyboard reads saw a key held; paging lock %s.",
                 key_hits, board.lock ? "reached" : "not reached");
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: presents queued words, holds each until accepted, and predicts
    // the result at the edge where the word is taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit send_now;
        send_now = 1'b0;
        if (!i_rst_n) begin
            event_ch.valid <= 1'b0;
        end else begin
            if (event_ch.valid && event_ch.ready) begin
                outcome_queue.push_back(predict_outcome(event_ch.data));
                words_sent++;
            end
            if (!event_ch.valid || event_ch.ready) begin
                if (event_queue.size() != 0) begin
                    if (event_queue[0].drain_first && words_sent != results_seen) begin
                        send_now = 1'b0;
                    end else if ((words_sent < 700 || words_sent >= 950)
                                 && $urandom_range(0, 99) < IDLE_PCT) begin
                        send_now = 1'b0;
                    end else begin
                        send_now = 1'b1;
                    end
                end
                if (send_now) begin
                    event_ch.data <= event_queue[0].word;
                    void'(event_queue.pop_front());
                end
                event_ch.valid <= send_now;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: random backpressure, and a field-by-field compare of each
    // accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        hcio_pkg::t_out_word want;
        hcio_pkg::t_out_word got;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (outcome_queue.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with no event outstanding, actual %0h",
                             $time, got);
                end else begin
                    want = outcome_queue.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("border_color", 8'(want.border_color),
                                8'(got.border_color));
                    check_field("speaker_level", 8'(want.speaker_level),
                                8'(got.speaker_level));
                    check_field("ram_bank", 8'(want.ram_bank), 8'(got.ram_bank));
                    check_field("rom_bank", 8'(want.rom_bank), 8'(got.rom_bank));
                    check_field("shadow_screen", 8'(want.shadow_screen),
                                8'(got.shadow_screen));
                    check_field("paging_locked", 8'(want.paging_locked),
                                8'(got.paging_locked));
                    check_field("turbo_on", 8'(want.turbo_on), 8'(got.turbo_on));
                    check_field("rom_hooks_on", 8'(want.rom_hooks_on),
                                8'(got.rom_hooks_on));
                    check_field("led_bits", 8'(want.led_bits), 8'(got.led_bits));
                    check_field("any_key_on_read", 8'(want.any_key_on_read),
                                8'(got.any_key_on_read));
                    check_field("all_keys_released", 8'(want.all_keys_released),
                                8'(got.all_keys_released));
                    if (want.any_key_on_read) begin
                        key_hits++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            // A stretch of results goes through with the sink always ready.
            if (results_seen >= 350 && results_seen < 650) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles in a row with neither side moving a word.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((event_ch.valid && event_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d of %0d results seen",
                     $time, STALL_LIMIT, results_seen, total_events);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
